// ----- rtl/core/planar_pose_compose_invert_unit_defines.svh -----
// Shared assertion macros for the pose unit.
`ifndef PLANAR_POSE_COMPOSE_INVERT_UNIT_DEFINES_SVH
`define PLANAR_POSE_COMPOSE_INVERT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPCI_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ppci same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PPCI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ppci next-cycle check failed");

`endif

// ----- rtl/core/ppci_pkg.sv -----
package ppci_pkg;

  localparam int ROTATION_STAGES = 16;
  localparam int MAX_STAGES      = 32;
  localparam int STAGE_IDX_W     = 5;
  // Q16.32 working format with headroom for quadrant turn and CORDIC gain
  localparam int DATA_W          = 52;

  localparam logic OP_INVERT  = 1'b0;
  localparam logic OP_COMPOSE = 1'b1;

  // 0.60725293500888 in Q31
  localparam logic signed [31:0] GAIN_INV_Q31 = 32'sh4DBA76D4;

  localparam logic [31:0] ATAN_STEPS [MAX_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [31:0]       pos_t;
  typedef logic signed [15:0]       angle_t;
  typedef logic signed [31:0]       zang_t;

  typedef struct packed {
    logic   compose;
    pos_t   first_x;
    pos_t   first_y;
    angle_t heading;
  } side_t;

  typedef struct packed {
    logic  vld;
    data_t x;
    data_t y;
    zang_t z;
    side_t side;
  } cord_t;

endpackage

// ----- rtl/core/ppci_front.sv -----
module ppci_front
  import ppci_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   accept,
  input  logic   operation,
  input  pos_t   first_x,
  input  pos_t   first_y,
  input  angle_t first_heading,
  input  pos_t   second_x,
  input  pos_t   second_y,
  input  angle_t second_heading,
  output cord_t  dout
);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic        s1_vld_r;
  data_t       s1_x_r, s1_y_r;
  logic [1:0]  s1_q_r;
  zang_t       s1_z_r;
  side_t       s1_side_r;

  logic        compose;
  pos_t        vec_x, vec_y;
  logic [15:0] ang, ang_ofs, resid;
  logic signed [63:0] prod_x, prod_y;
  data_t       pre_x_nxt, pre_y_nxt;
  zang_t       z_nxt;
  side_t       side_nxt;
  cord_t       dout_r, dout_nxt;

  always_comb begin
    compose   = (operation == OP_COMPOSE);
    vec_x     = compose ? second_x : first_x;
    vec_y     = compose ? second_y : first_y;
    ang       = compose ? first_heading : 16'(-first_heading);
    ang_ofs   = ang + 16'd8192;
    resid     = {2'b00, ang_ofs[13:0]} - 16'd8192;
    z_nxt     = {resid, 16'h0000};
    prod_x    = vec_x * GAIN_INV_Q31;
    prod_y    = vec_y * GAIN_INV_Q31;
    pre_x_nxt = DATA_W'(prod_x >>> 15);
    pre_y_nxt = DATA_W'(prod_y >>> 15);
    side_nxt.compose = compose;
    side_nxt.first_x = first_x;
    side_nxt.first_y = first_y;
    side_nxt.heading = compose ? 16'(first_heading + second_heading)
                               : 16'(-first_heading);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
    s1_x_r    <= pre_x_nxt;
    s1_y_r    <= pre_y_nxt;
    s1_q_r    <= ang_ofs[15:14];
    s1_z_r    <= z_nxt;
    s1_side_r <= side_nxt;
  end

  // turn by whole quarter turns, the cells handle the residual
  always_comb begin
    dout_nxt      = dout_r;
    dout_nxt.vld  = s1_vld_r;
    dout_nxt.z    = s1_z_r;
    dout_nxt.side = s1_side_r;
    case (s1_q_r)
      QUAD_0: begin
        dout_nxt.x = s1_x_r;
        dout_nxt.y = s1_y_r;
      end
      QUAD_1: begin
        dout_nxt.x = -s1_y_r;
        dout_nxt.y = s1_x_r;
      end
      QUAD_2: begin
        dout_nxt.x = -s1_x_r;
        dout_nxt.y = -s1_y_r;
      end
      QUAD_3: begin
        dout_nxt.x = s1_y_r;
        dout_nxt.y = -s1_x_r;
      end
      default: begin
        dout_nxt.x = s1_x_r;
        dout_nxt.y = s1_y_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout_r.vld <= 1'b0;
    end else begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

// ----- rtl/core/ppci_cell.sv -----
`include "planar_pose_compose_invert_unit_defines.svh"

module ppci_cell
  import ppci_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [STAGE_IDX_W-1:0] stage_idx,
  input  cord_t                  din,
  output cord_t                  dout
);

  data_t dx, dy;
  zang_t step;
  cord_t dout_r, dout_nxt;

  always_comb begin
    dx   = din.y >>> stage_idx;
    dy   = din.x >>> stage_idx;
    step = $signed(ATAN_STEPS[stage_idx]);
    dout_nxt      = din;
    // steer the residual angle toward zero
    if (!din.z[31]) begin
      dout_nxt.x = din.x - dx;
      dout_nxt.y = din.y + dy;
      dout_nxt.z = din.z - step;
    end else begin
      dout_nxt.x = din.x + dx;
      dout_nxt.y = din.y - dy;
      dout_nxt.z = din.z + step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout_r.vld <= 1'b0;
    end else begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

  `PPCI_ASSERT_NEXT(a_cell_side_kept, clk, rst_n, din.vld,
    dout.vld && (dout.side == $past(din.side)))
  `PPCI_ASSERT_NEXT(a_cell_z_moves, clk, rst_n, din.vld,
    ($past(din.z[31]) && (dout.z >= $past(din.z))) ||
    (!$past(din.z[31]) && (dout.z <= $past(din.z))))

endmodule

// ----- rtl/core/ppci_back.sv -----
`include "planar_pose_compose_invert_unit_defines.svh"

module ppci_back
  import ppci_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  cord_t  din,
  output logic   out_valid,
  output pos_t   result_x,
  output pos_t   result_y,
  output angle_t result_heading
);

  localparam data_t ROUND_HALF = data_t'(32768);

  data_t  rnd_x, rnd_y, shx, shy;
  pos_t   rot_x, rot_y;
  logic   valid_r;
  pos_t   x_r, y_r, x_nxt, y_nxt;
  angle_t head_r;

  always_comb begin
    rnd_x = din.x + ROUND_HALF;
    rnd_y = din.y + ROUND_HALF;
    shx   = rnd_x >>> 16;
    shy   = rnd_y >>> 16;
    rot_x = shx[31:0];
    rot_y = shy[31:0];
    if (din.side.compose == OP_COMPOSE) begin
      x_nxt = din.side.first_x + rot_x;
      y_nxt = din.side.first_y + rot_y;
    end else begin
      x_nxt = -rot_x;
      y_nxt = -rot_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= din.vld;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    head_r <= din.side.heading;
  end

  assign out_valid      = valid_r;
  assign result_x       = x_r;
  assign result_y       = y_r;
  assign result_heading = head_r;

  `PPCI_ASSERT_NEXT(a_back_beat_out, clk, rst_n, din.vld,
    out_valid && (result_heading == $past(din.side.heading)))

endmodule

// ----- rtl/core/planar_pose_compose_invert_unit.sv -----
// Channel   Handshake            Payload
// input     start / busy         in_operation, in_first_*, in_second_*
// result    out_valid (strobe)   out_result_x, out_result_y, out_result_heading
//
// One beat enters per cycle; busy stays low, so start is always taken.
// A beat passes the prescale multiply register, the quarter-turn
// register, one CORDIC cell per stage, then the rounding/add register.
// Synchronous active-low reset clears the valid bits of every stage.
// The receiver cannot stall: each result is shown for exactly one cycle.
module planar_pose_compose_invert_unit
  import ppci_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  output logic   busy,
  input  logic   in_operation,
  input  pos_t   in_first_x,
  input  pos_t   in_first_y,
  input  angle_t in_first_heading,
  input  pos_t   in_second_x,
  input  pos_t   in_second_y,
  input  angle_t in_second_heading,
  output logic   out_valid,
  output pos_t   out_result_x,
  output pos_t   out_result_y,
  output angle_t out_result_heading
);

  cord_t chain [ROTATION_STAGES+1];

  assign busy = 1'b0;

  ppci_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (start && !busy),
    .operation      (in_operation),
    .first_x        (in_first_x),
    .first_y        (in_first_y),
    .first_heading  (in_first_heading),
    .second_x       (in_second_x),
    .second_y       (in_second_y),
    .second_heading (in_second_heading),
    .dout           (chain[0])
  );

  for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_cell
    ppci_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (STAGE_IDX_W'(i)),
      .din       (chain[i]),
      .dout      (chain[i+1])
    );
  end

  ppci_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .din            (chain[ROTATION_STAGES]),
    .out_valid      (out_valid),
    .result_x       (out_result_x),
    .result_y       (out_result_y),
    .result_heading (out_result_heading)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
  import ppci_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic   op;
    pos_t   fx;
    pos_t   fy;
    angle_t fh;
    pos_t   sx;
    pos_t   sy;
    angle_t sh;
  } pose_req_t;

  typedef struct {
    pos_t   x;
    pos_t   y;
    angle_t heading;
  } pose_res_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  logic   in_operation = OP_INVERT;
  pos_t   in_first_x = '0;
  pos_t   in_first_y = '0;
  angle_t in_first_heading = '0;
  pos_t   in_second_x = '0;
  pos_t   in_second_y = '0;
  angle_t in_second_heading = '0;
  logic   out_valid;
  pos_t   out_result_x;
  pos_t   out_result_y;
  angle_t out_result_heading;

  pose_res_t expected_poses[$];
  int        error_count = 0;
  int        quiet_cycles = 0;
  bit        idle_bursts = 1'b1;

  planar_pose_compose_invert_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_first_x        (in_first_x),
    .in_first_y        (in_first_y),
    .in_first_heading  (in_first_heading),
    .in_second_x       (in_second_x),
    .in_second_y       (in_second_y),
    .in_second_heading (in_second_heading),
    .out_valid         (out_valid),
    .out_result_x      (out_result_x),
    .out_result_y      (out_result_y),
    .out_result_heading(out_result_heading)
  );

  always #1 clk = ~clk;

  // Gain-compensated CORDIC rotation of (vx, vy) by a binary angle, back in Q16.16.
  function automatic void rotate_vector(input longint vx, input longint vy,
                                        input logic [15:0] angle,
                                        output longint rx, output longint ry);
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    longint      t;
    logic [15:0] a;
    x = (vx * longint'(GAIN_INV_Q31)) >>> 15;
    y = (vy * longint'(GAIN_INV_Q31)) >>> 15;
    a = angle + 16'd8192;
    z = (longint'(a[13:0]) - 64'sd8192) * 64'sd65536;
    case (a[15:14])
      2'd1: begin
        t = x;
        x = -y;
        y = t;
      end
      2'd2: begin
        x = -x;
        y = -y;
      end
      2'd3: begin
        t = x;
        x = y;
        y = -t;
      end
      default: ;
    endcase
    for (int i = 0; i < ROTATION_STAGES && i < MAX_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_STEPS[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_STEPS[i]);
      end
    end
    rx = (x + 64'sd32768) >>> 16;
    ry = (y + 64'sd32768) >>> 16;
  endfunction

  function automatic pose_res_t predict_pose(input pose_req_t req);
    pose_res_t   res;
    longint      rx;
    longint      ry;
    longint      px;
    longint      py;
    logic [15:0] h;
    if (req.op == OP_COMPOSE) begin
      rotate_vector(longint'(req.sx), longint'(req.sy), req.fh, rx, ry);
      px = longint'(req.fx) + rx;
      py = longint'(req.fy) + ry;
      h = req.fh + req.sh;
    end else begin
      rotate_vector(longint'(req.fx), longint'(req.fy), 16'd0 - req.fh, rx, ry);
      px = -rx;
      py = -ry;
      h = 16'd0 - req.fh;
    end
    res.x = px[31:0];
    res.y = py[31:0];
    res.heading = h;
    return res;
  endfunction

  function automatic pose_req_t make_pose(input logic op, input pos_t fx, input pos_t fy,
                                          input angle_t fh, input pos_t sx,
                                          input pos_t sy, input angle_t sh);
    pose_req_t req;
    req.op = op;
    req.fx = fx;
    req.fy = fy;
    req.fh = fh;
    req.sx = sx;
    req.sy = sy;
    req.sh = sh;
    return req;
  endfunction

  function automatic pos_t rand_pos();
    logic [31:0] r;
    case ($urandom_range(0, 7))
      0: r = 32'h7FFFFFFF;
      1: r = 32'h80000000;
      2: r = $urandom_range(0, 2097151) - 32'd1048576;
      default: r = $urandom;
    endcase
    return r;
  endfunction

  function automatic angle_t rand_angle();
    logic [31:0] r;
    case ($urandom_range(0, 7))
      0: r = 32'h8000;
      1: r = 32'h7FFF;
      // land next to a quarter-turn boundary of the rotator
      2: r = $urandom_range(0, 3) * 32'd16384 + 32'd8192 - $urandom_range(0, 1);
      default: r = $urandom;
    endcase
    return r[15:0];
  endfunction

  function automatic pose_req_t rand_pose();
    logic op;
    op = $urandom_range(0, 1) ? OP_COMPOSE : OP_INVERT;
    return make_pose(op, rand_pos(), rand_pos(), rand_angle(),
                     rand_pos(), rand_pos(), rand_angle());
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic send_pose(input pose_req_t req);
    // idle with noise on the payload, start low
    if (idle_bursts && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 5)) begin
        @(negedge clk);
        start <= 1'b0;
        in_operation <= 1'($urandom_range(0, 1));
        in_first_x <= $urandom;
        in_first_y <= $urandom;
        in_first_heading <= 16'($urandom_range(0, 65535));
        in_second_x <= $urandom;
        in_second_y <= $urandom;
        in_second_heading <= 16'($urandom_range(0, 65535));
      end
    end
    @(negedge clk);
    start <= 1'b1;
    in_operation <= req.op;
    in_first_x <= req.fx;
    in_first_y <= req.fy;
    in_first_heading <= req.fh;
    in_second_x <= req.sx;
    in_second_y <= req.sy;
    in_second_heading <= req.sh;
    do @(posedge clk); while (busy);
    expected_poses.push_back(predict_pose(req));
  endtask

  task automatic test_directed_corners();
    pos_t pmax;
    pos_t pmin;
    pmax = 32'sh7FFFFFFF;
    pmin = 32'sh80000000;
    send_pose(make_pose(OP_INVERT, 0, 0, 0, 0, 0, 0));
    send_pose(make_pose(OP_COMPOSE, 0, 0, 0, 0, 0, 0));
    send_pose(make_pose(OP_COMPOSE, 32'sh10000, 32'sh20000, 0, 32'sh30000, -32'sh8000, 100));
    send_pose(make_pose(OP_COMPOSE, 0, 0, 16384, 32'sh10000, 0, 0));
    send_pose(make_pose(OP_COMPOSE, 0, 0, -16384, 32'sh10000, 32'sh10000, 0));
    // heading sums to pi and must come back as -pi
    send_pose(make_pose(OP_COMPOSE, 0, 0, 16384, 32'sh10000, 0, 16384));
    send_pose(make_pose(OP_COMPOSE, 0, 0, 16'sh7FFF, 32'sh10000, 0, 16'sh7FFF));
    // negating -pi stays -pi
    send_pose(make_pose(OP_INVERT, 32'sh10000, 32'sh10000, 16'sh8000, 0, 0, 0));
    send_pose(make_pose(OP_INVERT, 32'sh10000, -32'sh10000, 16'sh7FFF, pmax, pmin, 1));
    // residual angle extremes on each side of the quadrant split
    send_pose(make_pose(OP_COMPOSE, 0, 0, 8191, 32'sh40000, 32'sh40000, 0));
    send_pose(make_pose(OP_COMPOSE, 0, 0, 8192, 32'sh40000, 32'sh40000, 0));
    send_pose(make_pose(OP_COMPOSE, 0, 0, -8192, 32'sh40000, 32'sh40000, 0));
    send_pose(make_pose(OP_COMPOSE, 0, 0, -8193, 32'sh40000, 32'sh40000, 0));
    // positions wrap on overflow
    send_pose(make_pose(OP_COMPOSE, pmax, pmax, 0, pmax, pmax, 0));
    send_pose(make_pose(OP_COMPOSE, pmin, pmin, 0, pmin, pmin, 0));
    send_pose(make_pose(OP_COMPOSE, pmax, pmin, 16'sh8000, pmax, pmin, 16'sh8000));
    send_pose(make_pose(OP_INVERT, pmin, pmin, 0, 0, 0, 0));
    send_pose(make_pose(OP_INVERT, pmax, pmax, 0, 0, 0, 0));
    send_pose(make_pose(OP_INVERT, pmin, pmax, 16'sh4000, pmax, pmax, 16'sh7FFF));
    send_pose(make_pose(OP_INVERT, -1, -1, -1, -1, -1, -1));
    send_pose(make_pose(OP_COMPOSE, -1, -1, -1, -1, -1, -1));
    send_pose(make_pose(OP_COMPOSE, 1, 1, 1, 1, 1, 1));
  endtask

  task automatic test_random_poses(input int count);
    repeat (count) send_pose(rand_pose());
  endtask

  task automatic test_back_to_back(input int count);
    idle_bursts = 1'b0;
    repeat (count) send_pose(rand_pose());
  endtask

  always @(posedge clk) begin
    pose_res_t want;
    if (rst_n && out_valid) begin
      if (expected_poses.size() == 0) begin
        report_mismatch($sformatf("unexpected result x=%0d y=%0d heading=%0d",
                                  out_result_x, out_result_y, out_result_heading));
      end else begin
        want = expected_poses.pop_front();
        if (out_result_x !== want.x)
          report_mismatch($sformatf("result_x got %0d want %0d", out_result_x, want.x));
        if (out_result_y !== want.y)
          report_mismatch($sformatf("result_y got %0d want %0d", out_result_y, want.y));
        if (out_result_heading !== want.heading)
          report_mismatch($sformatf("result_heading got %0d want %0d",
                                    out_result_heading, want.heading));
      end
    end
  end

  // Count cycles with no beat on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_corners();
    test_random_poses(320);
    test_back_to_back(80);
    @(negedge clk);
    start <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (ROTATION_STAGES + 8) @(posedge clk);
    if (error_count == 0 && expected_poses.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
